// ===== rtl/core/srsc_pkg.sv =====
// shared types and constants for the segment to rectangle-set collision block
package srsc_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned DenW     = 33;
  localparam int unsigned ProdW    = 66;
  localparam int unsigned MaxRects = 64;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_TEST  = 1'b1
  } func_t;

  localparam logic [0:0] REG_RECT_COUNT = 1'b0;

  typedef struct packed {
    logic                     is_test;
    logic [5:0]               entry;
    logic signed [CoordW-1:0] xmin;
    logic signed [CoordW-1:0] xmax;
    logic signed [CoordW-1:0] ymin;
    logic signed [CoordW-1:0] ymax;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
  } req_t;

  typedef struct packed {
    logic signed [DiffW:0] n;
    logic [DenW-1:0]       d;
  } frac_t;

endpackage

// ===== rtl/core/srsc_ram.sv =====
// generic single-port-write ram with registered read
module srsc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/srsc_front.sv =====
// request front end: takes requests into a two-entry queue
module srsc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  srsc_pkg::req_t push_req,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output srsc_pkg::req_t head
);

  srsc_pkg::req_t q_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign head  = q_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r;
    wr_nxt  = wr_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = ~wr_r;
    end
    if (pop) begin
      rd_nxt = ~rd_r;
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_r] <= push_req;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !avail |-> !pop) else $error("queue underflow");
  a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("bad queue count");
`endif

endmodule

// ===== rtl/core/srsc_back.sv =====
// back end: walks the rectangle table one test at a time and clips the segment edge by edge
module srsc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           avail,
  input  srsc_pkg::req_t head,
  output logic           pop,
  input  logic [6:0]     rect_count,
  output logic           res_valid,
  output logic           res_hit
);

  localparam int unsigned MaxRects = srsc_pkg::MaxRects;
  localparam int unsigned AW = (MaxRects > 1) ? $clog2(MaxRects) : 1;
  localparam int unsigned CW = $clog2(MaxRects + 1);
  localparam int unsigned W  = srsc_pkg::CoordW;
  localparam int unsigned MW = srsc_pkg::CoordW + 1;
  localparam int unsigned PW = srsc_pkg::ProdW;
  localparam int unsigned DenW = srsc_pkg::DenW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_CHECK = 6'b000100,
    S_EDGE  = 6'b001000,
    S_FINAL = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt, lim_r, lim_nxt;
  logic [1:0]    edge_r, edge_nxt;
  logic [1:0]    cmp_r, cmp_nxt; // comparison step within an edge
  logic          hit_r, hit_nxt;
  srsc_pkg::frac_t u1_r, u1_nxt, u2_r, u2_nxt, t_r, t_nxt;
  logic [PW-1:0] pa_r, pb_r;
  logic          pv_r;
  srsc_pkg::req_t seg_r;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [127:0]   rdata;
  logic signed [W-1:0] x0, x1, y0, y1;

  assign we    = avail && !head.is_test && (state_r == S_IDLE);
  assign waddr = head.entry[AW-1:0];
  assign raddr = idx_r[AW-1:0];

  srsc_ram #(.Width(128), .Depth(MaxRects)) u_ram (
    .clk   (clk),
    .we    (we && ({26'd0, head.entry} < 32'(MaxRects))),
    .waddr (waddr),
    .wdata ({head.ymax, head.ymin, head.xmax, head.xmin}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign x0 = rdata[31:0];
  assign x1 = rdata[63:32];
  assign y0 = rdata[95:64];
  assign y1 = rdata[127:96];

  logic signed [W:0] ax, ay, bx, by, dx, dy;
  assign ax = {seg_r.ax[W-1], seg_r.ax};
  assign ay = {seg_r.ay[W-1], seg_r.ay};
  assign bx = {seg_r.bx[W-1], seg_r.bx};
  assign by = {seg_r.by[W-1], seg_r.by};
  assign dx = bx - ax;
  assign dy = by - ay;

  // edge parameters p and q for the current edge
  logic signed [W+1:0] p, q;
  always_comb begin
    unique case (edge_r)
      2'd0: begin
        p = -{dx[W], dx};
        q = {ax[W], ax} - {{2{x0[W-1]}}, x0};
      end
      2'd1: begin
        p = {dx[W], dx};
        q = {{2{x1[W-1]}}, x1} - {ax[W], ax};
      end
      2'd2: begin
        p = -{dy[W], dy};
        q = {ay[W], ay} - {{2{y0[W-1]}}, y0};
      end
      default: begin
        p = {dy[W], dy};
        q = {{2{y1[W-1]}}, y1} - {ay[W], ay};
      end
    endcase
  end

  // comparison operands for the multiplier
  srsc_pkg::frac_t ca, cb;
  logic [W:0] mag_a, mag_b;
  logic signed [1:0] sgn_a, sgn_b;
  always_comb begin
    ca = t_r;
    cb = u1_r;
    priority case (state_r)
      S_FINAL: begin
        ca = u2_r;
        cb = u1_r;
      end
      default: begin
        if (cmp_r == 2'd1) begin
          ca = t_r;
          cb = (p[W+1]) ? u2_r : u1_r;
        end else begin
          ca = t_r;
          cb = (p[W+1]) ? u1_r : u2_r;
        end
      end
    endcase
    mag_a = ca.n[W+1] ? MW'(0) - ca.n[W:0] : ca.n[W:0];
    mag_b = cb.n[W+1] ? MW'(0) - cb.n[W:0] : cb.n[W:0];
    sgn_a = (ca.n == '0) ? 2'sd0 : (ca.n[W+1] ? -2'sd1 : 2'sd1);
    sgn_b = (cb.n == '0) ? 2'sd0 : (cb.n[W+1] ? -2'sd1 : 2'sd1);
  end

  logic signed [1:0] sa_r, sb_r;
  logic signed [1:0] cmp_res;
  always_comb begin
    if (sa_r != sb_r) begin
      cmp_res = (sa_r < sb_r) ? -2'sd1 : 2'sd1;
    end else if (sa_r == 2'sd0) begin
      cmp_res = 2'sd0;
    end else if (pa_r == pb_r) begin
      cmp_res = 2'sd0;
    end else begin
      cmp_res = ((pa_r > pb_r) == (sa_r > 0)) ? 2'sd1 : -2'sd1;
    end
  end

  logic bbox_miss, inside_a, inside_b;
  logic signed [W-1:0] mnx, mxx, mny, mxy;
  assign mnx = (seg_r.ax < seg_r.bx) ? seg_r.ax : seg_r.bx;
  assign mxx = (seg_r.ax < seg_r.bx) ? seg_r.bx : seg_r.ax;
  assign mny = (seg_r.ay < seg_r.by) ? seg_r.ay : seg_r.by;
  assign mxy = (seg_r.ay < seg_r.by) ? seg_r.by : seg_r.ay;
  assign bbox_miss = (mxx < x0) || (mnx > x1) || (mxy < y0) || (mny > y1);
  assign inside_a = (seg_r.ax > x0) && (seg_r.ax < x1) && (seg_r.ay > y0) && (seg_r.ay < y1);
  assign inside_b = (seg_r.bx > x0) && (seg_r.bx < x1) && (seg_r.by > y0) && (seg_r.by < y1);

  logic signed [W+1:0] p_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    edge_nxt  = edge_r;
    cmp_nxt   = cmp_r;
    hit_nxt   = hit_r;
    u1_nxt    = u1_r;
    u2_nxt    = u2_r;
    t_nxt     = t_r;
    pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (avail) begin
          pop = 1'b1;
          if (head.is_test) begin
            idx_nxt = '0;
            hit_nxt = 1'b0;
            lim_nxt = ({1'b0, rect_count} > 8'(MaxRects)) ? CW'(MaxRects) : CW'(rect_count);
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (hit_r || idx_r >= lim_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (bbox_miss) begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_READ;
        end else if (inside_a || inside_b) begin
          hit_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          edge_nxt  = 2'd0;
          cmp_nxt   = 2'd0;
          u1_nxt    = '{n: '0, d: 33'd1};
          u2_nxt    = '{n: 34'sd1, d: 33'd1};
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        // step 0 loads t, step 1 multiplies, step 2 reject test, step 3 update
        priority case (cmp_r)
          2'd0: begin
            if (p == '0) begin
              if (q[W+1]) begin
                idx_nxt = idx_r + 1'b1;
                state_nxt = S_READ;
              end else if (edge_r == 2'd3) begin
                cmp_nxt = 2'd0;
                state_nxt = S_FINAL;
              end else begin
                edge_nxt = edge_r + 1'b1;
              end
            end else begin
              t_nxt.n = p[W+1] ? -q : q;
              t_nxt.d = p[W+1] ? DenW'(-p) : DenW'(p);
              cmp_nxt = 2'd1;
            end
          end
          2'd1: begin
            cmp_nxt = 2'd2;
          end
          2'd2: begin
            if ((p_r[W+1] && cmp_res > 0) || (!p_r[W+1] && cmp_res < 0)) begin
              idx_nxt = idx_r + 1'b1;
              state_nxt = S_READ;
            end else begin
              cmp_nxt = 2'd3;
            end
          end
          default: begin
            if (pv_r) begin
              if (p_r[W+1] && cmp_res > 0) u1_nxt = t_r;
              if (!p_r[W+1] && cmp_res < 0) u2_nxt = t_r;
              cmp_nxt = 2'd0;
              if (edge_r == 2'd3) begin
                state_nxt = S_FINAL;
              end else begin
                edge_nxt = edge_r + 1'b1;
              end
            end
          end
        endcase
      end
      S_FINAL: begin
        if (cmp_r == 2'd2) begin
          if (cmp_res > 0) begin
            hit_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = S_READ;
          end
          cmp_nxt = 2'd0;
        end else begin
          cmp_nxt = cmp_r + 1'b1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // products registered; in cmp step 1 t is compared with the bound that can
  // reject it, in step 2 with the bound that it may replace
  srsc_pkg::frac_t cb2;
  logic [W:0] mag_b2;
  logic signed [1:0] sgn_b2;
  always_comb begin
    cb2 = (state_r == S_FINAL) ? u1_r : (p_r[W+1] ? u1_r : u2_r);
    if (state_r == S_EDGE && cmp_r == 2'd2) begin
      cb2 = p_r[W+1] ? u1_r : u2_r;
    end else if (state_r == S_EDGE) begin
      cb2 = p_r[W+1] ? u2_r : u1_r;
    end
    mag_b2 = cb2.n[W+1] ? MW'(0) - cb2.n[W:0] : cb2.n[W:0];
    sgn_b2 = (cb2.n == '0) ? 2'sd0 : (cb2.n[W+1] ? -2'sd1 : 2'sd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      lim_r   <= '0;
      edge_r  <= '0;
      cmp_r   <= '0;
      hit_r   <= 1'b0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      lim_r   <= lim_nxt;
      edge_r  <= edge_nxt;
      cmp_r   <= cmp_nxt;
      hit_r   <= hit_nxt;
      pv_r    <= (state_r == S_EDGE && cmp_r == 2'd2);
    end
    u1_r <= u1_nxt;
    u2_r <= u2_nxt;
    t_r  <= t_nxt;
    if (state_r == S_EDGE && cmp_r == 2'd0) begin
      p_r <= p;
    end
    if (state_r == S_IDLE && avail && head.is_test) begin
      seg_r <= head;
    end
    if (state_r == S_FINAL) begin
      pa_r <= PW'(mag_a) * PW'(u1_r.d);
      pb_r <= PW'(mag_b) * PW'(u2_r.d);
      sa_r <= sgn_a;
      sb_r <= sgn_b;
    end else begin
      pa_r <= PW'(mag_a) * PW'(cb2.d);
      pb_r <= PW'(mag_b2) * PW'(t_r.d);
      sa_r <= sgn_a;
      sb_r <= sgn_b2;
    end
  end

  assign res_valid = (state_r == S_DONE);
  assign res_hit   = hit_r;

`ifndef SYNTH
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !res_valid) else $error("repeated result");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> idx_r < lim_r) else $error("index past limit");
`endif

endmodule

// ===== rtl/core/segment_rect_set_collision.sv =====
// top level of the segment to rectangle-set collision block
//
// usage:
//  - in_ channel: a request is taken when start is high and busy is low;
//    in_func selects a rectangle write (entry and rect bounds) or a
//    segment test (endpoints)
//  - a write request produces no result; a test request produces one
//    result, shown on out_hit for a single cycle with out_valid high
//  - cfg_ port: apb-style, register rect_count at byte address 0,
//    pready is tied high, reads return the current value
//  - a test walks the table rectangle by rectangle: each rectangle is first
//    checked against the segment's bounding box and for an inside endpoint,
//    and only then clipped edge by edge with a final span check, all
//    comparisons going through the registered compare products
//  - the walk stops early on the first hit; a write request is done in the idle state
//  - requests wait in a two-entry queue; busy rises when it is full
//  - reset clears the queue, the walker and rect_count; table contents
//    are undefined until written
//  - the receiver cannot stall results
module segment_rect_set_collision (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [5:0]         in_entry,
  input  logic signed [31:0] in_rect_xmin,
  input  logic signed [31:0] in_rect_xmax,
  input  logic signed [31:0] in_rect_ymin,
  input  logic signed [31:0] in_rect_ymax,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  output logic               out_valid,
  output logic               out_hit,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [6:0] cfg_rect_count_r;
  srsc_pkg::req_t req, head;
  logic full, avail, pop, push;

  assign pready = 1'b1;
  assign prdata = (paddr == srsc_pkg::REG_RECT_COUNT) ? {25'd0, cfg_rect_count_r} : 32'd0;

  // register write at the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rect_count_r <= 7'd0;
    end else if (psel && penable && pwrite && paddr == srsc_pkg::REG_RECT_COUNT) begin
      cfg_rect_count_r <= pwdata[6:0];
    end
  end

  assign busy = full;
  assign push = start && !busy;

  // pack the request fields
  always_comb begin
    req.is_test = (in_func == srsc_pkg::FUNC_TEST);
    req.entry   = in_entry;
    req.xmin    = in_rect_xmin;
    req.xmax    = in_rect_xmax;
    req.ymin    = in_rect_ymin;
    req.ymax    = in_rect_ymax;
    req.ax      = in_start_x;
    req.ay      = in_start_y;
    req.bx      = in_end_x;
    req.by      = in_end_y;
  end

  srsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (req),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  srsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .avail      (avail),
    .head       (head),
    .pop        (pop),
    .rect_count (cfg_rect_count_r),
    .res_valid  (out_valid),
    .res_hit    (out_hit)
  );

`ifndef SYNTH
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !push) else $error("request taken while busy");
  a_result_from_test: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid)) else $error("back-to-back results");
  a_ready_high: assert property (@(posedge clk) disable iff (!rst_n)
    pready) else $error("pready low");
`endif

endmodule
